/* rtl/ptts_pkg.sv */
package ptts_pkg;

    // Field widths
    localparam int OP_W     = 3;
    localparam int ID_W     = 3;
    localparam int PERIOD_W = 16;
    localparam int DELAY_W  = 8;
    localparam int MASK_W   = 8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_CREATE  = 3'd0;
    localparam logic [OP_W-1:0] OP_SUSPEND = 3'd1;
    localparam logic [OP_W-1:0] OP_RESUME  = 3'd2;
    localparam logic [OP_W-1:0] OP_DELETE  = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK    = 3'd4;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;     // capture a transfer
        logic exec;     // apply a table operation
        logic scan_en;  // issue a read of the next task during a tick
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic scan_last; // the read being issued is for the last task
    } stat_t;

endpackage

/* rtl/ptts_ctrl.sv */
module ptts_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [ptts_pkg::OP_W-1:0] op,
    input  ptts_pkg::stat_t           stat,
    output ptts_pkg::cmd_t            cmd,
    output logic                      busy,
    output logic                      done
);

    ptts_pkg::state_t state_reg;
    ptts_pkg::state_t state_next;
    logic             done_reg;
    logic             done_next;

    // State and strobe registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptts_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        busy        = 1'b1;
        done_next   = 1'b0;
        case (state_reg)
            ptts_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
                if (start)
                begin
                    if (op == ptts_pkg::OP_TICK)
                        state_next = ptts_pkg::ST_SCAN;
                    else if (op < ptts_pkg::OP_TICK)
                        state_next = ptts_pkg::ST_EXEC;
                end
            end
            ptts_pkg::ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ptts_pkg::ST_IDLE;
            end
            ptts_pkg::ST_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (stat.scan_last)
                    state_next = ptts_pkg::ST_DRAIN;
            end
            ptts_pkg::ST_DRAIN:
            begin
                // last task is written back this cycle; mask is final after it
                done_next  = 1'b1;
                state_next = ptts_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ptts_pkg::ST_IDLE;
            end
        endcase
    end

    assign done = done_reg;

`ifndef SYNTHESIS
    // Result strobe only follows the end of a scan
    a_done_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ptts_pkg::ST_DRAIN))
        else $error("done without a completed scan");

    // Accepted tick starts a scan
    a_tick_scans: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op == ptts_pkg::OP_TICK) |=> state_reg == ptts_pkg::ST_SCAN)
        else $error("tick did not start a scan");

    // Scan ends after the last task read
    a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ptts_pkg::ST_SCAN && stat.scan_last)
            |=> state_reg == ptts_pkg::ST_DRAIN)
        else $error("scan did not drain after last task");

    // Table operation returns to idle in the cycle after it is applied
    a_exec_once: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ptts_pkg::ST_EXEC |=> state_reg == ptts_pkg::ST_IDLE)
        else $error("table operation did not complete");
`endif

endmodule

/* rtl/ptts_dp.sv */
module ptts_dp #(
    parameter int TASK_COUNT = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ptts_pkg::cmd_t                cmd,
    output ptts_pkg::stat_t               stat,
    input  logic [ptts_pkg::OP_W-1:0]     op,
    input  logic [ptts_pkg::ID_W-1:0]     task_id,
    input  logic [ptts_pkg::PERIOD_W-1:0] period,
    input  logic [ptts_pkg::DELAY_W-1:0]  first_delay,
    output logic [ptts_pkg::MASK_W-1:0]   fired_mask
);

    localparam int IDX_W = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;

    // Captured transfer
    logic [ptts_pkg::OP_W-1:0]     op_reg;
    logic [ptts_pkg::ID_W-1:0]     id_reg;
    logic [ptts_pkg::PERIOD_W-1:0] period_reg;
    logic [ptts_pkg::DELAY_W-1:0]  delay_reg;

    // Per-task flags
    logic [TASK_COUNT-1:0] present_reg;
    logic [TASK_COUNT-1:0] ready_reg;

    // Period and countdown tables
    logic [ptts_pkg::PERIOD_W-1:0] period_mem [TASK_COUNT];
    logic [ptts_pkg::PERIOD_W-1:0] cnt_mem    [TASK_COUNT];

    // Scan pipeline: read stage, then update stage
    logic [IDX_W-1:0]              scan_idx_reg;
    logic                          s2_valid_reg;
    logic [IDX_W-1:0]              s2_idx_reg;
    logic [ptts_pkg::PERIOD_W-1:0] rd_period_reg;
    logic [ptts_pkg::PERIOD_W-1:0] rd_cnt_reg;
    logic [ptts_pkg::MASK_W-1:0]   mask_reg;
    logic [ptts_pkg::MASK_W-1:0]   mask_next;

    logic                          id_ok;
    logic [IDX_W-1:0]              id_idx;
    logic                          crt_we;
    logic                          active;
    logic                          cnt_zero;
    logic [ptts_pkg::PERIOD_W-1:0] cnt_new;

    // Operation decode
    always_comb
    begin
        id_ok    = (32'(id_reg) < TASK_COUNT);
        id_idx   = IDX_W'(id_reg);
        crt_we   = cmd.exec && id_ok && (op_reg == ptts_pkg::OP_CREATE);
        stat.scan_last = (32'(scan_idx_reg) == TASK_COUNT - 1);
    end

    // Countdown update for the task in the update stage
    always_comb
    begin
        active    = s2_valid_reg && present_reg[s2_idx_reg] && ready_reg[s2_idx_reg];
        cnt_zero  = (rd_cnt_reg == '0);
        cnt_new   = cnt_zero ? (rd_period_reg - 16'd1) : (rd_cnt_reg - 16'd1);
        mask_next = mask_reg;
        if (active && cnt_zero && (32'(s2_idx_reg) < ptts_pkg::MASK_W))
            mask_next[3'(s2_idx_reg)] = 1'b1;
    end

    // Transfer capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= op;
            id_reg     <= task_id;
            period_reg <= period;
            delay_reg  <= first_delay;
        end
    end

    // Flags, scan index, pipeline valid and mask
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg  <= '0;
            ready_reg    <= '0;
            scan_idx_reg <= '0;
            s2_valid_reg <= 1'b0;
            mask_reg     <= '0;
        end
        else
        begin
            s2_valid_reg <= cmd.scan_en;
            if (cmd.load)
            begin
                scan_idx_reg <= '0;
                mask_reg     <= '0;
            end
            else
            begin
                if (cmd.scan_en && !stat.scan_last)
                    scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                mask_reg <= mask_next;
            end
            if (cmd.exec && id_ok)
            begin
                case (op_reg)
                    ptts_pkg::OP_CREATE:
                    begin
                        present_reg[id_idx] <= 1'b1;
                        ready_reg[id_idx]   <= 1'b1;
                    end
                    ptts_pkg::OP_SUSPEND: ready_reg[id_idx]   <= 1'b0;
                    ptts_pkg::OP_RESUME:  ready_reg[id_idx]   <= 1'b1;
                    ptts_pkg::OP_DELETE:  present_reg[id_idx] <= 1'b0;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Table memories: one read port for the scan, one write port
    always_ff @(posedge clk)
    begin
        s2_idx_reg    <= scan_idx_reg;
        rd_period_reg <= period_mem[scan_idx_reg];
        rd_cnt_reg    <= cnt_mem[scan_idx_reg];
        if (crt_we)
        begin
            period_mem[id_idx] <= period_reg;
            cnt_mem[id_idx]    <= {{(ptts_pkg::PERIOD_W - ptts_pkg::DELAY_W){1'b0}}, delay_reg};
        end
        else if (active)
        begin
            cnt_mem[s2_idx_reg] <= cnt_new;
        end
    end

    assign fired_mask = mask_reg;

endmodule

/* rtl/periodic_task_tick_scheduler.sv */
// Channel   Handshake             Fields
// -------   --------------------  --------------------------------------
// command   start in, busy out    op, task_id, period, first_delay
// result    done out (strobe)     fired_mask
//
// A command transfers at a clock edge with start high and busy low.
// Create, suspend, resume and delete hold busy while the table operation is applied.
// A tick walks the task table one entry per cycle through a single read port: busy
// while it reads every entry and writes back the last, done pulses once the mask is final.
// Reset (rst_n low, asynchronous) clears all task flags; no task is present.
// The result is shown for one cycle with done and cannot be held off.
module periodic_task_tick_scheduler #(
    parameter int TASK_COUNT = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ptts_pkg::OP_W-1:0]     op,
    input  logic [ptts_pkg::ID_W-1:0]     task_id,
    input  logic [ptts_pkg::PERIOD_W-1:0] period,
    input  logic [ptts_pkg::DELAY_W-1:0]  first_delay,
    output logic                          done,
    output logic [ptts_pkg::MASK_W-1:0]   fired_mask
);

    ptts_pkg::cmd_t  cmd;
    ptts_pkg::stat_t stat;

    // Sequencer
    ptts_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Task table and tick datapath
    ptts_dp #(
        .TASK_COUNT (TASK_COUNT)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .op          (op),
        .task_id     (task_id),
        .period      (period),
        .first_delay (first_delay),
        .fired_mask  (fired_mask)
    );

endmodule

/* verif/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TASK_COUNT = 8;
    // Highest op code; everything above OP_TICK is unused
    localparam logic [ptts_pkg::OP_W-1:0] OP_MAX = '1;

    logic                          clk         = 1'b0;
    logic                          rst_n       = 1'b0;
    logic                          start       = 1'b0;
    logic [ptts_pkg::OP_W-1:0]     op          = ptts_pkg::OP_TICK;
    logic [ptts_pkg::ID_W-1:0]     task_id     = '0;
    logic [ptts_pkg::PERIOD_W-1:0] period      = '0;
    logic [ptts_pkg::DELAY_W-1:0]  first_delay = '0;
    logic                          busy;
    logic                          done;
    logic [ptts_pkg::MASK_W-1:0]   fired_mask;

    periodic_task_tick_scheduler #(
        .TASK_COUNT (TASK_COUNT)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .task_id     (task_id),
        .period      (period),
        .first_delay (first_delay),
        .done        (done),
        .fired_mask  (fired_mask)
    );

    always #6 clk = ~clk;

    // Shadow copy of the task table
    logic                          tbl_present [TASK_COUNT];
    logic                          tbl_ready   [TASK_COUNT];
    logic [ptts_pkg::PERIOD_W-1:0] tbl_reload  [TASK_COUNT];
    logic [ptts_pkg::PERIOD_W-1:0] tbl_count   [TASK_COUNT];

    logic [ptts_pkg::MASK_W-1:0] pending_masks [$];

    int idle_pct     = 0;
    int mask_errors  = 0;
    int cmd_count    = 0;
    int tick_count   = 0;
    int fire_count   = 0;
    int unused_count = 0;

    // One tick of the schedule: fire expired tasks, count down the others
    function automatic logic [ptts_pkg::MASK_W-1:0] advance_tick();
        logic [ptts_pkg::MASK_W-1:0] fired;
        fired = '0;
        for (int i = 0; i < TASK_COUNT; i++)
        begin
            if (tbl_present[i] && tbl_ready[i])
            begin
                if (tbl_count[i] == '0)
                begin
                    tbl_count[i] = tbl_reload[i] - 16'd1;
                    if (i < ptts_pkg::MASK_W)
                        fired[i] = 1'b1;
                end
                else
                begin
                    tbl_count[i] = tbl_count[i] - 16'd1;
                end
            end
        end
        return fired;
    endfunction

    // Update the shadow table for one accepted command
    function automatic void apply_command(
        input logic [ptts_pkg::OP_W-1:0]     c_op,
        input logic [ptts_pkg::ID_W-1:0]     c_id,
        input logic [ptts_pkg::PERIOD_W-1:0] c_per,
        input logic [ptts_pkg::DELAY_W-1:0]  c_dly
    );
        cmd_count++;
        if (c_op == ptts_pkg::OP_TICK)
        begin
            pending_masks.push_back(advance_tick());
            tick_count++;
        end
        else if (c_op > ptts_pkg::OP_TICK || c_id >= TASK_COUNT)
        begin
            unused_count++;
        end
        else
        begin
            case (c_op)
                ptts_pkg::OP_CREATE:
                begin
                    tbl_reload[c_id]  = c_per;
                    tbl_count[c_id]   =
                        {{(ptts_pkg::PERIOD_W-ptts_pkg::DELAY_W){1'b0}}, c_dly};
                    tbl_present[c_id] = 1'b1;
                    tbl_ready[c_id]   = 1'b1;
                end
                ptts_pkg::OP_SUSPEND: tbl_ready[c_id] = 1'b0;
                ptts_pkg::OP_RESUME:  tbl_ready[c_id] = 1'b1;
                ptts_pkg::OP_DELETE:  tbl_present[c_id] = 1'b0;
                default:    ;
            endcase
        end
    endfunction

    // Drive one command, with random idle cycles ahead of it; returns after the transfer
    task automatic issue(
        input logic [ptts_pkg::OP_W-1:0]     c_op,
        input logic [ptts_pkg::ID_W-1:0]     c_id,
        input logic [ptts_pkg::PERIOD_W-1:0] c_per,
        input logic [ptts_pkg::DELAY_W-1:0]  c_dly
    );
        logic accepted;
        while ($urandom_range(99) < idle_pct)
        begin
            // junk on the fields while start is low
            start       <= 1'b0;
            op          <= ptts_pkg::OP_W'($urandom);
            task_id     <= ptts_pkg::ID_W'($urandom);
            period      <= ptts_pkg::PERIOD_W'($urandom);
            first_delay <= ptts_pkg::DELAY_W'($urandom);
            @(posedge clk);
        end
        start       <= 1'b1;
        op          <= c_op;
        task_id     <= c_id;
        period      <= c_per;
        first_delay <= c_dly;
        accepted = 1'b0;
        while (!accepted)
        begin
            @(posedge clk);
            accepted = !busy;
        end
        apply_command(c_op, c_id, c_per, c_dly);
    endtask

    // Random command; mostly small periods and delays so tasks fire often
    task automatic issue_random(input int tick_pct);
        logic [ptts_pkg::OP_W-1:0]     r_op;
        logic [ptts_pkg::PERIOD_W-1:0] r_per;
        logic [ptts_pkg::DELAY_W-1:0]  r_dly;
        int                            pick;
        pick = $urandom_range(99);
        if ($urandom_range(99) < tick_pct)
            r_op = ptts_pkg::OP_TICK;
        else if (pick < 40)
            r_op = ptts_pkg::OP_CREATE;
        else if (pick < 55)
            r_op = ptts_pkg::OP_SUSPEND;
        else if (pick < 75)
            r_op = ptts_pkg::OP_RESUME;
        else if (pick < 90)
            r_op = ptts_pkg::OP_DELETE;
        else
            r_op = ptts_pkg::OP_W'($urandom_range(ptts_pkg::OP_TICK + 1, OP_MAX));
        r_per = ($urandom_range(3) == 0) ? ptts_pkg::PERIOD_W'($urandom)
                                         : ptts_pkg::PERIOD_W'($urandom_range(6));
        r_dly = ($urandom_range(4) == 0) ? ptts_pkg::DELAY_W'($urandom)
                                         : ptts_pkg::DELAY_W'($urandom_range(5));
        issue(r_op, ptts_pkg::ID_W'($urandom), r_per, r_dly);
    endtask

    // Extremes of the fields and each corner of the table operations
    task automatic test_directed();
        issue(ptts_pkg::OP_CREATE, 3'd0, 16'h0000, 8'h00);   // period zero, fires at once
        issue(ptts_pkg::OP_TICK, 3'd0, 16'h0000, 8'h00);     // reload wraps to all ones
        issue(ptts_pkg::OP_CREATE, 3'd7, 16'hFFFF, 8'hFF);
        issue(ptts_pkg::OP_CREATE, 3'd3, 16'h0001, 8'h01);
        issue(ptts_pkg::OP_TICK, 3'd0, 16'h0000, 8'h00);
        issue(ptts_pkg::OP_TICK, 3'd0, 16'h0000, 8'h00);
        issue(ptts_pkg::OP_TICK, 3'd0, 16'h0000, 8'h00);
        issue(ptts_pkg::OP_SUSPEND, 3'd3, 16'h0000, 8'h00);
        issue(ptts_pkg::OP_TICK, 3'd0, 16'h0000, 8'h00);
        issue(ptts_pkg::OP_RESUME, 3'd3, 16'h0000, 8'h00);
        issue(ptts_pkg::OP_TICK, 3'd0, 16'h0000, 8'h00);
        // flag changes on tasks that were never created
        issue(ptts_pkg::OP_SUSPEND, 3'd5, 16'h0000, 8'h00);
        issue(ptts_pkg::OP_RESUME, 3'd6, 16'h0000, 8'h00);
        issue(ptts_pkg::OP_TICK, 3'd0, 16'h0000, 8'h00);
        issue(ptts_pkg::OP_DELETE, 3'd0, 16'h0000, 8'h00);
        issue(ptts_pkg::OP_TICK, 3'd0, 16'h0000, 8'h00);
        // create over a task that is already present
        issue(ptts_pkg::OP_CREATE, 3'd7, 16'h0002, 8'h00);
        issue(ptts_pkg::OP_TICK, 3'd0, 16'h0000, 8'h00);
        issue(ptts_pkg::OP_TICK, 3'd0, 16'h0000, 8'h00);
        for (int c = ptts_pkg::OP_TICK + 1; c <= OP_MAX; c++)
            issue(ptts_pkg::OP_W'(c), ptts_pkg::ID_W'($urandom),
                  ptts_pkg::PERIOD_W'($urandom), ptts_pkg::DELAY_W'($urandom));
        issue(ptts_pkg::OP_TICK, 3'd0, 16'h0000, 8'h00);
        // delete then resume: still must not fire
        issue(ptts_pkg::OP_DELETE, 3'd3, 16'h0000, 8'h00);
        issue(ptts_pkg::OP_RESUME, 3'd3, 16'h0000, 8'h00);
        issue(ptts_pkg::OP_TICK, 3'd0, 16'h0000, 8'h00);
    endtask

    // Fill the table, then a table-heavy mix with occasional sender gaps
    task automatic test_table_ops();
        idle_pct = 19;
        for (int i = 0; i < TASK_COUNT; i++)
            issue(ptts_pkg::OP_CREATE, ptts_pkg::ID_W'(i),
                  ptts_pkg::PERIOD_W'($urandom_range(4)),
                  ptts_pkg::DELAY_W'($urandom_range(3)));
        repeat (420)
            issue_random(35);
    endtask

    // Tick-heavy mix with long sender gaps
    task automatic test_tick_storm();
        idle_pct = 70;
        for (int i = 0; i < TASK_COUNT; i++)
            issue(ptts_pkg::OP_CREATE, ptts_pkg::ID_W'(i),
                  ptts_pkg::PERIOD_W'($urandom_range(3)),
                  ptts_pkg::DELAY_W'($urandom_range(2)));
        repeat (420)
            issue_random(60);
    endtask

    // Commands back to back with no gaps
    task automatic test_back_to_back();
        idle_pct = 0;
        repeat (420)
            issue_random(50);
    endtask

    // Wait for outstanding masks, then let the pipeline settle
    task automatic wait_drain();
        int guard;
        guard = 0;
        while (pending_masks.size() != 0 && guard < 2000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (TASK_COUNT + 4) @(posedge clk);
    endtask

    // Compare every result transfer with the oldest expected mask
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_masks.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual fired_mask=%h",
                         $realtime, fired_mask);
                mask_errors++;
            end
            else
            begin
                logic [ptts_pkg::MASK_W-1:0] want;
                want = pending_masks.pop_front();
                if (fired_mask !== want)
                begin
                    $display("%0t: fired_mask mismatch, expected %h actual %h",
                             $realtime, want, fired_mask);
                    mask_errors++;
                end
                if (want != '0)
                    fire_count++;
            end
        end
    end

    initial
    begin
        for (int i = 0; i < TASK_COUNT; i++)
        begin
            tbl_present[i] = 1'b0;
            tbl_ready[i]   = 1'b0;
            tbl_reload[i]  = '0;
            tbl_count[i]   = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_table_ops();
        test_tick_storm();
        test_back_to_back();
        start <= 1'b0;
        wait_drain();

        if (pending_masks.size() != 0)
        begin
            $display("%0t: %0d expected masks never arrived, expected 0 actual %0d",
                     $realtime, pending_masks.size(), pending_masks.size());
            mask_errors++;
        end
        $display("run covered %0d commands: %0d ticks, %0d with tasks firing, %0d unused ops",
                 cmd_count, tick_count, fire_count, unused_count);
        $display("sender gaps at 19%%, 70%% and none; %0d mismatches", mask_errors);
        if (mask_errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #5_000_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule
